@@ rtl/imu_sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_pkg
// Types and constants shared by the serial IMU frame decoder modules.
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

    localparam int FRAME_BYTES   = 11;
    localparam int POS_W         = 4;
    localparam int PAYLOAD_BYTES = 6;
    localparam int PAY_IDX_W     = 3;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 12;
    localparam int FS_W          = 12;
    localparam int RAW_W         = 16;
    localparam int SCALED_W      = 28;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_HEADER     = 4'd0,
        REG_ACCEL_CODE       = 4'd1,
        REG_GYRO_CODE        = 4'd2,
        REG_ANGLE_CODE       = 4'd3,
        REG_MAG_CODE         = 4'd4,
        REG_ACCEL_FULL_SCALE = 4'd5,
        REG_GYRO_FULL_SCALE  = 4'd6,
        REG_ANGLE_FULL_SCALE = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_OK       = 2'd1,
        STATUS_CHECKSUM = 2'd2,
        STATUS_UNKNOWN  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_MAG   = 2'd3
    } kind_t;

    // One classified request passed from the parser to the scaling stage.
    typedef struct packed {
        status_t                  status;
        kind_t                    kind;
        logic signed [RAW_W-1:0]  raw_x;
        logic signed [RAW_W-1:0]  raw_y;
        logic signed [RAW_W-1:0]  raw_z;
        logic [FS_W-1:0]          full_scale;
        logic                     angle_fresh;
    } rec_t;

    // Handshake between a queue and its consumer.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

@@ rtl/imu_sfd_front.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_front
// Frame parser: tracks byte position and checksum, stores the frame and
// classifies it on the checksum byte. Holds the configuration registers.
// ----------------------------------------------------------------------------
module imu_sfd_front
    import imu_sfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   func,
    input  logic [7:0]             rx_byte,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output rec_t                   rec
);

    logic [7:0]       frame_header_reg, accel_code_reg, gyro_code_reg;
    logic [7:0]       angle_code_reg, mag_code_reg;
    logic [FS_W-1:0]  accel_fs_reg, gyro_fs_reg, angle_fs_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic             flag_reg, flag_next;
    logic [7:0]       type_reg;
    logic [7:0]       pay_reg [PAYLOAD_BYTES];
    logic             type_we, pay_we;
    logic [PAY_IDX_W-1:0] pay_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_header_reg <= 8'h55;
            accel_code_reg   <= 8'h51;
            gyro_code_reg    <= 8'h52;
            angle_code_reg   <= 8'h53;
            mag_code_reg     <= 8'h54;
            accel_fs_reg     <= 12'd16;
            gyro_fs_reg      <= 12'd2000;
            angle_fs_reg     <= 12'd180;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_HEADER:     frame_header_reg <= cfg_data[7:0];
                REG_ACCEL_CODE:       accel_code_reg   <= cfg_data[7:0];
                REG_GYRO_CODE:        gyro_code_reg    <= cfg_data[7:0];
                REG_ANGLE_CODE:       angle_code_reg   <= cfg_data[7:0];
                REG_MAG_CODE:         mag_code_reg     <= cfg_data[7:0];
                REG_ACCEL_FULL_SCALE: accel_fs_reg     <= cfg_data;
                REG_GYRO_FULL_SCALE:  gyro_fs_reg      <= cfg_data;
                REG_ANGLE_FULL_SCALE: angle_fs_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        flag_next = flag_reg;
        type_we   = 1'b0;
        pay_we    = 1'b0;
        pay_idx   = PAY_IDX_W'(pos_reg - POS_W'(2));

        rec.status        = STATUS_NONE;
        rec.kind          = KIND_ACCEL;
        rec.raw_x         = '0;
        rec.raw_y         = '0;
        rec.raw_z         = '0;
        rec.full_scale    = '0;

        if (func)
        begin
            flag_next = 1'b0;
        end
        else if (pos_reg == '0)
        begin
            if (rx_byte == frame_header_reg)
            begin
                sum_next = rx_byte;
                pos_next = POS_W'(1);
            end
        end
        else if (pos_reg < POS_W'(FRAME_BYTES - 1))
        begin
            if (pos_reg == POS_W'(1))
                type_we = 1'b1;
            else if (pos_reg < POS_W'(2 + PAYLOAD_BYTES))
                pay_we = 1'b1;
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = '0;
            sum_next = '0;
            if (sum_reg != rx_byte)
            begin
                rec.status = STATUS_CHECKSUM;
            end
            else
            begin
                // Priority order settles equal type codes.
                rec.status = STATUS_OK;
                if (type_reg == accel_code_reg)
                begin
                    rec.kind       = KIND_ACCEL;
                    rec.full_scale = accel_fs_reg;
                end
                else if (type_reg == gyro_code_reg)
                begin
                    rec.kind       = KIND_GYRO;
                    rec.full_scale = gyro_fs_reg;
                end
                else if (type_reg == angle_code_reg)
                begin
                    rec.kind       = KIND_ANGLE;
                    rec.full_scale = angle_fs_reg;
                    flag_next      = 1'b1;
                end
                else if (type_reg == mag_code_reg)
                begin
                    rec.kind       = KIND_MAG;
                    rec.full_scale = FS_W'(1);
                end
                else
                begin
                    rec.status = STATUS_UNKNOWN;
                end
                if (rec.status == STATUS_OK)
                begin
                    rec.raw_x = {pay_reg[1], pay_reg[0]};
                    rec.raw_y = {pay_reg[3], pay_reg[2]};
                    rec.raw_z = {pay_reg[5], pay_reg[4]};
                end
            end
        end
        rec.angle_fresh = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            flag_reg <= flag_next;
        end
    end

    // Frame storage is always written before it is read within a frame.
    always_ff @(posedge clk)
    begin
        if (accept && !func && type_we)
            type_reg <= rx_byte;
        if (accept && !func && pay_we)
            pay_reg[pay_idx] <= rx_byte;
    end

endmodule

@@ rtl/imu_sfd_queue.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_queue
// Short queue of classified requests between the parser and scaling stage.
// ----------------------------------------------------------------------------
module imu_sfd_queue
    import imu_sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  rec_t      wr_rec,
    input  logic      rd_en,
    output rec_t      rd_rec,
    output q_status_t stat
);

    rec_t                 slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign rd_rec     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

@@ rtl/imu_sfd_back.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_back
// Scaling stage: multiplies the samples by the full scale and holds the
// result in the output register until it is popped.
// ----------------------------------------------------------------------------
module imu_sfd_back
    import imu_sfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  q_status_t                  q_stat,
    input  rec_t                       q_rec,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [1:0]                 status,
    output logic [1:0]                 kind,
    output logic signed [RAW_W-1:0]    raw_x,
    output logic signed [RAW_W-1:0]    raw_y,
    output logic signed [RAW_W-1:0]    raw_z,
    output logic signed [SCALED_W-1:0] scaled_x,
    output logic signed [SCALED_W-1:0] scaled_y,
    output logic signed [SCALED_W-1:0] scaled_z,
    output logic                       angle_fresh
);

    logic                        valid_reg;
    logic signed [FS_W:0]        fs_s;
    logic signed [SCALED_W:0]    prod_x, prod_y, prod_z;

    assign empty = !valid_reg;
    assign q_pop = !q_stat.empty && (!valid_reg || pop);

    assign fs_s   = $signed({1'b0, q_rec.full_scale});
    assign prod_x = q_rec.raw_x * fs_s;
    assign prod_y = q_rec.raw_y * fs_s;
    assign prod_z = q_rec.raw_z * fs_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status      <= q_rec.status;
            kind        <= q_rec.kind;
            raw_x       <= q_rec.raw_x;
            raw_y       <= q_rec.raw_y;
            raw_z       <= q_rec.raw_z;
            scaled_x    <= prod_x[SCALED_W-1:0];
            scaled_y    <= prod_y[SCALED_W-1:0];
            scaled_z    <= prod_z[SCALED_W-1:0];
            angle_fresh <= q_rec.angle_fresh;
        end
    end

endmodule

@@ rtl/imu_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Parser for 11-byte serial IMU frames with checksum, type decode and
// full-scale multiplication of the three samples.
// ----------------------------------------------------------------------------
// Usage: each request on the input side is either a received byte (func 0)
// or a command that clears the sticky angle flag (func 1). A request is
// taken when push is high and full is low. Every request yields exactly one
// result on the output side, in order: status, kind, raw and scaled samples
// and the current angle flag. The oldest result is shown while empty is low
// and is removed when pop is high.
// A request's result goes through the queue into the output register.
// Throughput is one request per cycle while full is low, set by the parser's
// position and checksum update and the combinational scaling multiply.
// If the receiver stalls, results back up into the output register and the
// two-entry queue behind it, after which full rises until pop resumes.
// Reset restores the default header, type codes and full scales, clears the
// position, checksum and angle flag, and empties the queue and output.
// Configuration writes use cfg_valid/cfg_ready, always ready, and should
// only be issued while no requests are in flight.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder
    import imu_sfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       func,
    input  logic [7:0]                 rx_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 status,
    output logic [1:0]                 kind,
    output logic signed [RAW_W-1:0]    raw_x,
    output logic signed [RAW_W-1:0]    raw_y,
    output logic signed [RAW_W-1:0]    raw_z,
    output logic signed [SCALED_W-1:0] scaled_x,
    output logic signed [SCALED_W-1:0] scaled_y,
    output logic signed [SCALED_W-1:0] scaled_z,
    output logic                       angle_fresh,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic      accept;
    rec_t      front_rec, q_rec;
    q_status_t q_stat;
    logic      q_pop;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    // A request enters the parser whenever the queue has room for its result.
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    imu_sfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec       (front_rec)
    );

    // The queue decouples the parser from a stalled receiver.
    imu_sfd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_rec (front_rec),
        .rd_en  (q_pop),
        .rd_rec (q_rec),
        .stat   (q_stat)
    );

    imu_sfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_rec       (q_rec),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .kind        (kind),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .raw_z       (raw_z),
        .scaled_x    (scaled_x),
        .scaled_y    (scaled_y),
        .scaled_z    (scaled_z),
        .angle_fresh (angle_fresh)
    );

endmodule

@@ sim/tb_imu_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// Testbench for imu_serial_frame_decoder
// Feeds serial bytes and flag-clear commands into the frame decoder and
// compares results with an in-bench decoder that follows the same framing,
// checksum, type lookup and full-scale rules. A short table of directed
// requests, some with fixed results, comes first. Then the bench runs several
// register profiles, the extremes among them, each with randomized frames,
// noise bytes and clear commands, while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_imu_serial_frame_decoder;
    import imu_sfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS       = 8;
    localparam int NUM_PROFILES   = 8;
    localparam int PHASE_REQUESTS = 105;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // One decoder result, laid out like the result ports.
    typedef struct packed {
        status_t                     status;
        kind_t                       kind;
        logic signed [RAW_W-1:0]     raw_x;
        logic signed [RAW_W-1:0]     raw_y;
        logic signed [RAW_W-1:0]     raw_z;
        logic signed [SCALED_W-1:0]  scaled_x;
        logic signed [SCALED_W-1:0]  scaled_y;
        logic signed [SCALED_W-1:0]  scaled_z;
        logic                        angle_fresh;
    } frame_result_t;

    // One request on the input side. When fixed_want is set, the result is
    // taken from want instead of the in-bench decoder.
    typedef struct {
        logic          fn;
        logic [7:0]    ch;
        bit            fixed_want;
        frame_result_t want;
    } byte_req_t;

    // A row of the directed table. Where has_want is set, the expected
    // result is an empty one with the given status and flag.
    typedef struct packed {
        logic       fn;
        logic [7:0] ch;
        logic       has_want;
        status_t    st;
        logic       flag;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 26;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Stray bytes right after reset are dropped while hunting for a header.
        '{1'b0, 8'h00, 1'b1, STATUS_NONE, 1'b0},
        '{1'b0, 8'hFF, 1'b1, STATUS_NONE, 1'b0},
        // A clear command with the flag already low.
        '{1'b1, 8'hFF, 1'b1, STATUS_NONE, 1'b0},
        // Angle frame carrying the sample extremes -32768, 32767 and -1.
        '{1'b0, 8'h55, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h53, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h00, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h80, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'hFF, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h7F, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'hFF, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'hFF, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h00, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h00, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'hA4, 1'b0, STATUS_NONE, 1'b0},
        // Acceleration frame interrupted by a clear command, which must keep
        // the frame going, and closed with a wrong checksum.
        '{1'b0, 8'h55, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h51, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h01, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h02, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h03, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h04, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h05, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h06, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h07, 1'b0, STATUS_NONE, 1'b0},
        '{1'b0, 8'h08, 1'b0, STATUS_NONE, 1'b0},
        '{1'b1, 8'h00, 1'b1, STATUS_NONE, 1'b0},
        '{1'b0, 8'h00, 1'b1, STATUS_CHECKSUM, 1'b0}
    };

    // Register profiles in register index order: header, the four type
    // codes, then the three full scales. One entry is replaced by random
    // values at run time.
    localparam int RANDOM_PROFILE = 6;
    localparam logic [CFG_DATA_W-1:0] REG_PROFILES [NUM_PROFILES][NUM_REGS] = '{
        '{12'hFF, 12'h00, 12'h01, 12'hFE, 12'h80, 12'd4095, 12'd4095, 12'd4095},
        '{12'h00, 12'hFF, 12'h7F, 12'h01, 12'hFE, 12'd1, 12'd1, 12'd1},
        '{12'hAA, 12'h51, 12'h52, 12'h53, 12'h54, 12'd0, 12'd0, 12'd0},
        '{12'h55, 12'h33, 12'h33, 12'h33, 12'h33, 12'd4095, 12'd7, 12'd100},
        '{12'h5A, 12'h41, 12'h42, 12'h42, 12'h42, 12'd3, 12'd4095, 12'd1},
        '{12'hA5, 12'h61, 12'h62, 12'h60, 12'h60, 12'd2000, 12'd16, 12'd4095},
        '{12'h00, 12'h00, 12'h00, 12'h00, 12'h00, 12'd0, 12'd0, 12'd0},
        '{12'h55, 12'h51, 12'h52, 12'h53, 12'h54, 12'd16, 12'd2000, 12'd180}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic                       func = 1'b0;
    logic [7:0]                 rx_byte = 8'h00;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [1:0]                 status;
    logic [1:0]                 kind;
    logic signed [RAW_W-1:0]    raw_x;
    logic signed [RAW_W-1:0]    raw_y;
    logic signed [RAW_W-1:0]    raw_z;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic signed [SCALED_W-1:0] scaled_z;
    logic                       angle_fresh;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    imu_serial_frame_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .kind        (kind),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .raw_z       (raw_z),
        .scaled_x    (scaled_x),
        .scaled_y    (scaled_y),
        .scaled_z    (scaled_z),
        .angle_fresh (angle_fresh),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Requests still to be sent, and results owed by the decoder in order.
    byte_req_t     tx_bytes [$];
    frame_result_t pending_results [$];
    byte_req_t     on_wire;
    int            mismatch_count = 0;

    // Mirror of the configuration registers, updated on each accepted write.
    // It spans the whole index range so that a register index selects it.
    logic [CFG_DATA_W-1:0] reg_mirror [1 << CFG_INDEX_W];

    // Parser state of the in-bench decoder.
    logic [POS_W-1:0] frame_pos = '0;
    logic [7:0]       frame_sum = '0;
    logic [7:0]       frame_type = '0;
    logic [7:0]       frame_payload [PAYLOAD_BYTES];
    logic             angle_flag = 1'b0;

    // Runs one request through the in-bench decoder and returns its result.
    // A frame is judged on its last byte: checksum first, then the type codes
    // in the order accel, gyro, angle, magnetometer, so the first equal code
    // wins. Magnetometer samples are passed with a scale of one.
    function automatic frame_result_t decode_step(input logic fn, input logic [7:0] ch);
        frame_result_t           res;
        logic [FS_W-1:0]         fs;
        logic signed [RAW_W-1:0] smp [3];
        res = '0;
        fs  = '0;
        if (fn) begin
            angle_flag = 1'b0;
        end
        else if (frame_pos == 0) begin
            // The header register is only looked at while hunting.
            if (ch == reg_mirror[REG_FRAME_HEADER][7:0]) begin
                frame_sum = ch;
                frame_pos = POS_W'(1);
            end
        end
        else if (frame_pos < FRAME_BYTES - 1) begin
            if (frame_pos == 1)
                frame_type = ch;
            else if (frame_pos < 8)
                frame_payload[PAY_IDX_W'(frame_pos - POS_W'(2))] = ch;
            frame_sum = frame_sum + ch;
            frame_pos = frame_pos + 1'b1;
        end
        else begin
            frame_pos = '0;
            if (frame_sum != ch) begin
                res.status = STATUS_CHECKSUM;
            end
            else begin
                res.status = STATUS_OK;
                if (frame_type == reg_mirror[REG_ACCEL_CODE][7:0]) begin
                    res.kind = KIND_ACCEL;
                    fs = reg_mirror[REG_ACCEL_FULL_SCALE];
                end
                else if (frame_type == reg_mirror[REG_GYRO_CODE][7:0]) begin
                    res.kind = KIND_GYRO;
                    fs = reg_mirror[REG_GYRO_FULL_SCALE];
                end
                else if (frame_type == reg_mirror[REG_ANGLE_CODE][7:0]) begin
                    res.kind = KIND_ANGLE;
                    fs = reg_mirror[REG_ANGLE_FULL_SCALE];
                end
                else if (frame_type == reg_mirror[REG_MAG_CODE][7:0]) begin
                    res.kind = KIND_MAG;
                    fs = FS_W'(1);
                end
                else begin
                    res.status = STATUS_UNKNOWN;
                end
                if (res.status == STATUS_OK) begin
                    // Samples are little endian: low byte first.
                    for (int k = 0; k < 3; k++)
                        smp[k] = {frame_payload[2*k+1], frame_payload[2*k]};
                    res.raw_x    = smp[0];
                    res.raw_y    = smp[1];
                    res.raw_z    = smp[2];
                    res.scaled_x = smp[0] * $signed({1'b0, fs});
                    res.scaled_y = smp[1] * $signed({1'b0, fs});
                    res.scaled_z = smp[2] * $signed({1'b0, fs});
                    if (res.kind == KIND_ANGLE)
                        angle_flag = 1'b1;
                end
            end
            frame_sum = '0;
        end
        res.angle_fresh = angle_flag;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Handshake engine. Everything is sampled at the rising edge, before the
    // decoder's own registers update, and driven back with nonblocking
    // assignments, so nothing depends on the order of processes in a step.
    // ------------------------------------------------------------------------
    int          burst_left = 1;
    int          gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;
    int          idle_cycles = 0;

    always @(posedge clk) begin : handshake_engine
        frame_result_t want;
        frame_result_t got;
        logic          sent;
        logic          next_push;
        if (rst_n) begin
            // Result side: compare the oldest owed result field by field.
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, status %0d", $time, status);
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("kind", want.kind, kind);
                    check_field("raw_x", want.raw_x, raw_x);
                    check_field("raw_y", want.raw_y, raw_y);
                    check_field("raw_z", want.raw_z, raw_z);
                    check_field("scaled_x", want.scaled_x, scaled_x);
                    check_field("scaled_y", want.scaled_y, scaled_y);
                    check_field("scaled_z", want.scaled_z, scaled_z);
                    check_field("angle_fresh", want.angle_fresh, angle_fresh);
                end
            end

            // Request side: an accepted request always advances the decoder
            // copy, even where the table fixes the expected result.
            sent = push && !full;
            if (sent) begin
                got = decode_step(on_wire.fn, on_wire.ch);
                pending_results.push_back(on_wire.fixed_want ? on_wire.want : got);
            end

            // The sender runs in bursts separated by random gaps; a held
            // request stays on the wires until full drops.
            if (!push || sent) begin
                next_push = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (tx_bytes.size() > 0) begin
                    on_wire   = tx_bytes.pop_front();
                    next_push = 1'b1;
                    func    <= on_wire.fn;
                    rx_byte <= on_wire.ch;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else begin
                        burst_left--;
                    end
                end
                push <= next_push;
            end

            // The receiver follows a rotating stall pattern that is replaced whenever
            // pattern_age wraps; one time in four it never stalls.
            pop <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 64) begin
                pattern_age   = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom()) | 16'h0001);
            end

            // Watchdog: any accepted request, result or register write counts
            // as progress.
            if (sent || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL imu_serial_frame_decoder");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_byte(input logic fn, input logic [7:0] ch);
        byte_req_t req;
        req.fn         = fn;
        req.ch         = ch;
        req.fixed_want = 1'b0;
        req.want       = '0;
        tx_bytes.push_back(req);
    endfunction

    // Payload bytes lean on the values that build the sample extremes.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom());
        endcase
    endfunction

    // Queues one frame under the current registers: mostly one of the four
    // known types with a good checksum, sometimes an unknown type or a bad
    // checksum, with an occasional clear command slipped between its bytes.
    task automatic queue_frame(inout int count);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] acc;
        fb[0] = reg_mirror[REG_FRAME_HEADER][7:0];
        case ($urandom_range(0, 9))
            0, 1:    fb[1] = reg_mirror[REG_ACCEL_CODE][7:0];
            2, 3:    fb[1] = reg_mirror[REG_GYRO_CODE][7:0];
            4, 5:    fb[1] = reg_mirror[REG_ANGLE_CODE][7:0];
            6, 7:    fb[1] = reg_mirror[REG_MAG_CODE][7:0];
            default: fb[1] = 8'($urandom());
        endcase
        for (int i = 2; i < FRAME_BYTES - 1; i++)
            fb[i] = payload_byte();
        acc = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            acc = acc + fb[i];
        fb[FRAME_BYTES-1] = ($urandom_range(0, 7) == 0) ? acc + 8'($urandom_range(1, 255))
                                                        : acc;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                queue_byte(1'b1, 8'($urandom()));
                count++;
            end
            queue_byte(1'b0, fb[i]);
            count++;
        end
    endtask

    // Bytes between frames; most avoid the header so they are dropped.
    task automatic queue_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom());
            if (b == reg_mirror[REG_FRAME_HEADER][7:0] && $urandom_range(0, 3) != 0)
                b = b ^ 8'h01;
            queue_byte(1'b0, b);
        end
    endtask

    // Random requests up to target, with stops of the sender past the middle
    // until every owed result has arrived, then a partial frame so that the next
    // register profile lands while the parser is inside a frame.
    task automatic run_random_phase();
        int count;
        count = 0;
        while (count < PHASE_REQUESTS) begin
            if ($urandom_range(0, 3) == 0)
                queue_noise();
            queue_frame(count);
            if (count >= PHASE_REQUESTS / 2 && count < PHASE_REQUESTS / 2 + FRAME_BYTES + 2)
                wait_idle();
        end
        queue_byte(1'b0, reg_mirror[REG_FRAME_HEADER][7:0]);
        repeat ($urandom_range(0, FRAME_BYTES - 2))
            queue_byte(1'b0, payload_byte());
        wait_idle();
    endtask

    // Idle means nothing left to send, nothing on the wires and nothing owed.
    // The check runs on the falling edge, once the rising edge has settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tx_bytes.size() != 0 || push || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_mirror[idx] = value;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        byte_req_t             req;
        logic [CFG_DATA_W-1:0] value;
        reg_mirror[REG_FRAME_HEADER]     = 12'h55;
        reg_mirror[REG_ACCEL_CODE]       = 12'h51;
        reg_mirror[REG_GYRO_CODE]        = 12'h52;
        reg_mirror[REG_ANGLE_CODE]       = 12'h53;
        reg_mirror[REG_MAG_CODE]         = 12'h54;
        reg_mirror[REG_ACCEL_FULL_SCALE] = 12'd16;
        reg_mirror[REG_GYRO_FULL_SCALE]  = 12'd2000;
        reg_mirror[REG_ANGLE_FULL_SCALE] = 12'd180;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            frame_payload[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset register values.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            req.fn         = DIRECTED[r].fn;
            req.ch         = DIRECTED[r].ch;
            req.fixed_want = DIRECTED[r].has_want;
            req.want       = '0;
            req.want.status      = DIRECTED[r].st;
            req.want.angle_fresh = DIRECTED[r].flag;
            tx_bytes.push_back(req);
        end
        wait_idle();
        run_random_phase();

        // Each profile rewrites every register while the decoder is idle.
        for (int p = 0; p < NUM_PROFILES; p++) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                value = (p == RANDOM_PROFILE) ? CFG_DATA_W'($urandom()) : REG_PROFILES[p][i];
                write_reg(cfg_reg_t'(i), value);
            end
            run_random_phase();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS imu_serial_frame_decoder");
        else
            $display("FAIL imu_serial_frame_decoder");
        $finish;
    end

endmodule
